FILE: design/exi_pkg.sv
// Shared types, constants and lookup tables for the expansion bus controller.
// Used by exi_boot and exi_bus_controller_with_ipl_unit; no dependencies.
package exi_pkg;

    localparam int CHANNEL_COUNT = 3;
    localparam int SRAM_BYTES    = 68;
    localparam int SRAM_RAM_DEPTH = SRAM_BYTES - 4;
    localparam int BANNER_LEN    = 85;

    localparam logic [31:0] BASE_A       = 32'h0c006800;
    localparam logic [31:0] BASE_B       = 32'h0d006800;
    localparam logic [6:0]  WINDOW_BYTES = 7'd60;
    localparam logic [31:0] EPOCH_OFFSET = 32'd946684800;
    localparam logic [24:0] RTC_FLAG_ADDR = 25'h0840020;
    localparam logic [17:0] SRAM_PAGE    = 18'h10000;

    // Register kinds inside one channel.
    localparam logic [2:0] REG_STATUS  = 3'd0;
    localparam logic [2:0] REG_DMA_ADR = 3'd1;
    localparam logic [2:0] REG_DMA_LEN = 3'd2;
    localparam logic [2:0] REG_CONTROL = 3'd3;
    localparam logic [2:0] REG_IMM     = 3'd4;

    // Transfer directions.
    localparam logic [1:0] DIR_READ  = 2'd0;
    localparam logic [1:0] DIR_WRITE = 2'd1;
    localparam logic [1:0] DIR_XCHG  = 2'd2;
    localparam logic [1:0] DIR_NONE  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_GATHER,
        S_APPLY,
        S_XSTART,
        S_XSTEP,
        S_XWAIT,
        S_XEND,
        S_DONE
    } exi_state_t;

    // One byte request to the boot device.
    typedef struct packed {
        logic       step;
        logic       clear;
        logic [7:0] din;
    } boot_req_t;

    localparam logic [7:0] BANNER [BANNER_LEN] = '{
        8'h28,8'h43,8'h29,8'h20,8'h31,8'h39,8'h39,8'h39,8'h2d,8'h32,8'h30,8'h30,8'h31,8'h20,
        8'h4e,8'h69,8'h6e,8'h74,8'h65,8'h6e,8'h64,8'h6f,8'h2e,8'h20,8'h20,8'h41,8'h6c,8'h6c,
        8'h20,8'h72,8'h69,8'h67,8'h68,8'h74,8'h73,8'h20,8'h72,8'h65,8'h73,8'h65,8'h72,8'h76,
        8'h65,8'h64,8'h2e,
        8'h28,8'h43,8'h29,8'h20,8'h31,8'h39,8'h39,8'h39,8'h20,8'h41,8'h72,8'h74,8'h58,8'h20,
        8'h49,8'h6e,8'h63,8'h2e,8'h20,8'h20,8'h41,8'h6c,8'h6c,8'h20,8'h72,8'h69,8'h67,8'h68,
        8'h74,8'h73,8'h20,8'h72,8'h65,8'h73,8'h65,8'h72,8'h76,8'h65,8'h64,8'h2e
    };

    // Common prefix of the two slot names.
    localparam logic [7:0] SLOT_TEXT [11] = '{
        8'h44,8'h4f,8'h4c,8'h50,8'h48,8'h49,8'h4e,8'h53,8'h4c,8'h4f,8'h54
    };

    // Power-on contents of one SRAM byte.
    function automatic logic [7:0] sram_init(input logic [6:0] idx);
        logic [7:0] v;
        v = 8'h00;
        case (idx)
            7'h05: v = 8'h2c;
            7'h06: v = 8'hff;
            7'h07: v = 8'hd0;
            7'h17: v = 8'h2c;
            7'h23: v = 8'h41;
            7'h2f: v = 8'h42;
            7'h3e: v = 8'h6e;
            7'h3f: v = 8'h6d;
            default:
            begin
                if (idx >= 7'h18 && idx < 7'h23)
                    v = SLOT_TEXT[4'(idx - 7'h18)];
                else if (idx >= 7'h24 && idx < 7'h2f)
                    v = SLOT_TEXT[4'(idx - 7'h24)];
            end
        endcase
        return v;
    endfunction

endpackage

FILE: design/exi_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module exi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read at the same address.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

FILE: design/exi_boot.sv
// Boot device on channel 0: command shifter, banner ROM, SRAM and RTC flag.
// Depends on exi_pkg and exi_ram. Answer byte is ready in the cycle after step.
module exi_boot
    import exi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  boot_req_t   req,
    input  logic [31:0] secs,
    output logic [7:0]  dout
);

    logic [31:0] command_reg, command_next;
    logic [2:0]  count_reg, count_next;
    logic [31:0] cursor_reg, cursor_next;
    logic [6:0]  curmod_reg, curmod_next;
    logic [7:0]  rtc_reg, rtc_next;
    logic [7:0]  stamp_reg [4];
    logic [7:0]  stamp_next [4];
    logic [SRAM_RAM_DEPTH-1:0] valid_reg, valid_next;
    logic        use_ram_reg, use_ram_next;
    logic [7:0]  hold_reg, hold_next;

    logic        wr;
    logic [24:0] dev_addr;
    logic [20:0] rom_idx;
    logic [32:0] sum33;
    logic [7:0]  s8;
    logic [7:0]  s1;
    logic [6:0]  sidx;
    logic [31:0] stamp_val;
    logic        ram_we;
    logic [5:0]  ram_addr;
    logic [7:0]  ram_q;

    exi_ram #(.WIDTH(8), .DEPTH(SRAM_RAM_DEPTH)) u_sram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (req.din),
        .rdata (ram_q)
    );

    assign wr       = command_reg[31];
    assign dev_addr = command_reg[30:6];
    assign rom_idx  = dev_addr[20:0] + cursor_reg[20:0];
    assign stamp_val = (secs > EPOCH_OFFSET) ? (secs - EPOCH_OFFSET) : 32'd0;

    // SRAM entry: offset plus cursor in 32 bits, modulo the SRAM size.
    always_comb
    begin
        sum33 = {1'b0, cursor_reg} + 33'(dev_addr[6:0]);
        s8    = 8'(dev_addr[6:0]) + 8'(curmod_reg);
        s1    = (s8 >= 8'(SRAM_BYTES)) ? s8 - 8'(SRAM_BYTES) : s8;
        if (sum33[32])
            s1 = (s1 >= 8'd52) ? s1 - 8'd52 : s1 + 8'd16;
        sidx     = s1[6:0];
        ram_addr = 6'(sidx - 7'd4);
    end

    // Byte handling for the command and data phases.
    always_comb
    begin
        command_next = command_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        curmod_next  = curmod_reg;
        rtc_next     = rtc_reg;
        stamp_next   = stamp_reg;
        valid_next   = valid_reg;
        use_ram_next = 1'b0;
        hold_next    = hold_reg;
        ram_we       = 1'b0;
        if (req.clear)
        begin
            command_next = 32'd0;
            count_next   = 3'd0;
            cursor_next  = 32'd0;
            curmod_next  = 7'd0;
        end
        else if (req.step)
        begin
            hold_next = 8'h00;
            if (count_reg < 3'd4)
            begin
                command_next = {command_reg[23:0], req.din};
                count_next   = count_reg + 3'd1;
                hold_next    = 8'hff;
                if (count_reg == 3'd3)
                begin
                    stamp_next[0] = stamp_val[31:24];
                    stamp_next[1] = stamp_val[23:16];
                    stamp_next[2] = stamp_val[15:8];
                    stamp_next[3] = stamp_val[7:0];
                end
            end
            else if (dev_addr[24:21] == 4'd0)
            begin
                cursor_next = cursor_reg + 32'd1;
                curmod_next = (cursor_reg == 32'hffffffff || curmod_reg == 7'd67) ?
                              7'd0 : curmod_reg + 7'd1;
                if (!wr && rom_idx[20:7] == 14'd0 && rom_idx[6:0] < 7'(BANNER_LEN))
                    hold_next = BANNER[rom_idx[6:0]];
            end
            else if (dev_addr[24:7] == SRAM_PAGE && dev_addr[6:0] < 7'(SRAM_BYTES))
            begin
                cursor_next = cursor_reg + 32'd1;
                curmod_next = (cursor_reg == 32'hffffffff || curmod_reg == 7'd67) ?
                              7'd0 : curmod_reg + 7'd1;
                if (wr)
                begin
                    if (sidx < 7'd4)
                        stamp_next[sidx[1:0]] = req.din;
                    else
                    begin
                        ram_we               = 1'b1;
                        valid_next[ram_addr] = 1'b1;
                    end
                end
                else if (sidx < 7'd4)
                    hold_next = stamp_reg[sidx[1:0]];
                else
                begin
                    use_ram_next = valid_reg[ram_addr];
                    hold_next    = sram_init(sidx);
                end
            end
            else if (dev_addr == RTC_FLAG_ADDR)
            begin
                if (wr)
                    rtc_next = req.din;
                else
                    hold_next = rtc_reg;
            end
        end
    end

    assign dout = use_ram_reg ? ram_q : hold_reg;

    // Device state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg <= 32'd0;
            count_reg   <= 3'd0;
            cursor_reg  <= 32'd0;
            curmod_reg  <= 7'd0;
            rtc_reg     <= 8'd0;
            stamp_reg   <= '{default: 8'd0};
            valid_reg   <= '0;
            use_ram_reg <= 1'b0;
            hold_reg    <= 8'd0;
        end
        else
        begin
            command_reg <= command_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            curmod_reg  <= curmod_next;
            rtc_reg     <= rtc_next;
            stamp_reg   <= stamp_next;
            valid_reg   <= valid_next;
            use_ram_reg <= use_ram_next;
            hold_reg    <= hold_next;
        end
    end

endmodule

FILE: design/exi_bus_controller_with_ipl_unit.sv
// Top level of the three-channel expansion bus controller with boot device.
// Depends on exi_pkg and exi_boot.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_stall  | cmd, phys_address, access_bytes,
//           |                      | write_value, unix_seconds
//  output   | out_valid / out_stall| read_value, claimed, irq_pending
//
// One sequencer walks the access one byte per cycle over a shared register port.
// A read shifts bytes in S_READ; a write gathers them in S_GATHER and applies
// each register in S_APPLY, where a started immediate transfer steps its bytes
// through S_XSTEP and S_XWAIT. An unclaimed access goes straight to S_DONE. Reset is
// asynchronous, active low, and needs no clearing pass. in_stall is high while an
// item is in work; a held result does not stop the next transfer from being taken.
module exi_bus_controller_with_ipl_unit
    import exi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [31:0] phys_address,
    input  logic [3:0]  access_bytes,
    input  logic [63:0] write_value,
    input  logic [31:0] unix_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] read_value,
    output logic        claimed,
    output logic        irq_pending
);

    exi_state_t state_reg, state_next;

    logic [13:0] status_reg [CHANNEL_COUNT];
    logic [13:0] status_next [CHANNEL_COUNT];
    logic [31:0] dma_addr_reg [CHANNEL_COUNT];
    logic [31:0] dma_addr_next [CHANNEL_COUNT];
    logic [31:0] dma_len_reg [CHANNEL_COUNT];
    logic [31:0] dma_len_next [CHANNEL_COUNT];
    logic [31:0] control_reg [CHANNEL_COUNT];
    logic [31:0] control_next [CHANNEL_COUNT];
    logic [31:0] imm_reg [CHANNEL_COUNT];
    logic [31:0] imm_next [CHANNEL_COUNT];

    logic        cmd_reg, cmd_next;
    logic        hit_reg, hit_next;
    logic [5:0]  off_reg, off_next;
    logic [3:0]  size_reg, size_next;
    logic [63:0] wval_reg, wval_next;
    logic [31:0] secs_reg, secs_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] rv_reg, rv_next;
    logic [31:0] gbits_reg [3];
    logic [31:0] gbits_next [3];
    logic [31:0] gmask_reg [3];
    logic [31:0] gmask_next [3];
    logic [1:0]  ngrp_reg, ngrp_next;
    logic [1:0]  gi_reg, gi_next;
    logic [1:0]  xch_reg, xch_next;
    logic [1:0]  xlen_reg, xlen_next;
    logic [1:0]  xdir_reg, xdir_next;
    logic        xboot_reg, xboot_next;
    logic        xupd_reg, xupd_next;
    logic [1:0]  xj_reg, xj_next;
    logic [31:0] xres_reg, xres_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] read_value_reg, read_value_next;
    logic        claimed_reg, claimed_next;
    logic        irq_reg, irq_next;

    logic [31:0] diff_a, diff_b;
    logic        in_a, in_b;
    logic [5:0]  in_off;
    logic [5:0]  cur;
    logic [5:0]  last_byte;
    logic [3:0]  ridx;
    logic [1:0]  rch;
    logic [2:0]  rkind;
    logic [31:0] rval;
    logic [1:0]  gidx;
    logic [2:0]  bpos;
    logic [7:0]  wbyte;
    logic [31:0] gb, gm;
    logic [13:0] st_old, st_new, st_dm, st_wmask;
    logic [31:0] ctl_new;
    logic [2:0]  xsel;
    logic [7:0]  xin;
    logic [7:0]  xout;
    logic        irq_any;
    logic        out_free;
    boot_req_t   boot_req;
    logic [7:0]  boot_dout;

    exi_boot u_boot (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (boot_req),
        .secs  (secs_reg),
        .dout  (boot_dout)
    );

    // Window decode for the incoming address.
    assign diff_a = phys_address - BASE_A;
    assign diff_b = phys_address - BASE_B;
    assign in_a   = diff_a < 32'(WINDOW_BYTES);
    assign in_b   = diff_b < 32'(WINDOW_BYTES);
    assign in_off = in_a ? diff_a[5:0] : diff_b[5:0];

    // Interrupt summary over all channels.
    always_comb
    begin
        irq_any = 1'b0;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            if ((status_reg[c][1] && status_reg[c][0]) ||
                (status_reg[c][3] && status_reg[c][2]) ||
                (status_reg[c][11] && status_reg[c][10]))
                irq_any = 1'b1;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer: next state and datapath.
    always_comb
    begin
        state_next      = state_reg;
        status_next     = status_reg;
        dma_addr_next   = dma_addr_reg;
        dma_len_next    = dma_len_reg;
        control_next    = control_reg;
        imm_next        = imm_reg;
        cmd_next        = cmd_reg;
        hit_next        = hit_reg;
        off_next        = off_reg;
        size_next       = size_reg;
        wval_next       = wval_reg;
        secs_next       = secs_reg;
        cnt_next        = cnt_reg;
        rv_next         = rv_reg;
        gbits_next      = gbits_reg;
        gmask_next      = gmask_reg;
        ngrp_next       = ngrp_reg;
        gi_next         = gi_reg;
        xch_next        = xch_reg;
        xlen_next       = xlen_reg;
        xdir_next       = xdir_reg;
        xboot_next      = xboot_reg;
        xupd_next       = xupd_reg;
        xj_next         = xj_reg;
        xres_next       = xres_reg;
        read_value_next = read_value_reg;
        claimed_next    = claimed_reg;
        irq_next        = irq_reg;
        out_valid_next  = out_valid_reg && out_stall;
        boot_req        = '0;

        // Register addressed by the current byte or the current group.
        cur       = 6'(off_reg + 6'(cnt_reg));
        last_byte = 6'(7'(off_reg) + 7'(size_reg) - 7'd1);
        if (state_reg == S_APPLY)
            ridx = 4'(off_reg[5:2] + 4'(gi_reg));
        else
            ridx = cur[5:2];
        rch   = (ridx >= 4'd10) ? 2'd2 : ((ridx >= 4'd5) ? 2'd1 : 2'd0);
        rkind = 3'(ridx - {rch, 2'b00} - 4'(rch));
        case (rkind)
            REG_STATUS:  rval = {18'd0, status_reg[rch] & ~14'h1000};
            REG_DMA_ADR: rval = dma_addr_reg[rch];
            REG_DMA_LEN: rval = dma_len_reg[rch];
            REG_CONTROL: rval = control_reg[rch];
            default:     rval = imm_reg[rch];
        endcase

        gidx  = 2'(cur[5:2] - off_reg[5:2]);
        bpos  = 3'(size_reg - 4'd1 - 4'(cnt_reg));
        wbyte = 8'(wval_reg >> {bpos, 3'b000});
        gb    = gbits_reg[gi_reg];
        gm    = gmask_reg[gi_reg];

        // Status write with write-one-clear interrupt bits.
        st_old   = status_reg[rch];
        st_wmask = 14'h03f5;
        if (rch != 2'd2)
            st_wmask = st_wmask | 14'h0400;
        if (rch == 2'd0)
            st_wmask = st_wmask | 14'h2000;
        st_dm  = gm[13:0] & st_wmask;
        st_new = (st_old & ~st_dm) | (gb[13:0] & st_dm);
        if (gm[1] && gb[1])
            st_new[1] = 1'b0;
        if (gm[3] && gb[3])
            st_new[3] = 1'b0;
        if (rch != 2'd2 && gm[11] && gb[11])
            st_new[11] = 1'b0;
        ctl_new = (control_reg[rch] & ~gm) | (gb & gm);

        xsel = status_reg[xch_reg][9:7];
        xin  = 8'(imm_reg[xch_reg] >> {~xj_reg, 3'b000});
        xout = (xboot_reg && (xdir_reg == DIR_READ || xdir_reg == DIR_XCHG)) ?
               boot_dout : 8'h00;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = cmd;
                    off_next  = in_off;
                    size_next = access_bytes;
                    wval_next = write_value;
                    secs_next = unix_seconds;
                    hit_next  = (in_a || in_b) && access_bytes != 4'd0 &&
                                access_bytes <= 4'd8 &&
                                (7'(in_off) + 7'(access_bytes)) <= WINDOW_BYTES;
                    cnt_next   = 3'd0;
                    rv_next    = 64'd0;
                    gbits_next = '{default: 32'd0};
                    gmask_next = '{default: 32'd0};
                    gi_next    = 2'd0;
                    if (!hit_next)
                        state_next = S_DONE;
                    else if (cmd)
                        state_next = S_GATHER;
                    else
                        state_next = S_READ;
                end
            end

            // One register byte per cycle; a status read clears EXT.
            S_READ:
            begin
                rv_next = {rv_reg[55:0], 8'(rval >> {~cur[1:0], 3'b000})};
                if (rkind == REG_STATUS)
                    status_next[rch][12] = 1'b0;
                if (4'(cnt_reg) == size_reg - 4'd1)
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg + 3'd1;
            end

            // Gather write bytes into per-register bits and masks.
            S_GATHER:
            begin
                gbits_next[gidx] = gbits_reg[gidx] | (32'(wbyte) << {~cur[1:0], 3'b000});
                gmask_next[gidx] = gmask_reg[gidx] | (32'hff << {~cur[1:0], 3'b000});
                if (4'(cnt_reg) == size_reg - 4'd1)
                begin
                    ngrp_next  = 2'(last_byte[5:2] - off_reg[5:2]);
                    state_next = S_APPLY;
                end
                else
                    cnt_next = cnt_reg + 3'd1;
            end

            // One masked register write per cycle, in rising order, paused while a started transfer runs.
            S_APPLY:
            begin
                case (rkind)
                    REG_STATUS:
                    begin
                        status_next[rch] = st_new;
                        if (rch == 2'd0 && st_new[9:7] != st_old[9:7] &&
                            st_new[9:7] == 3'd2)
                            boot_req.clear = 1'b1;
                    end
                    REG_DMA_ADR: dma_addr_next[rch] = (dma_addr_reg[rch] & ~gm) | (gb & gm);
                    REG_DMA_LEN: dma_len_next[rch] = (dma_len_reg[rch] & ~gm) | (gb & gm);
                    REG_CONTROL: control_next[rch] = ctl_new;
                    default:     imm_next[rch] = (imm_reg[rch] & ~gm) | (gb & gm);
                endcase
                if (rkind == REG_CONTROL && gm[0] && ctl_new[0])
                begin
                    xch_next   = rch;
                    state_next = S_XSTART;
                end
                else if (gi_reg == ngrp_reg)
                    state_next = S_DONE;
                else
                    gi_next = gi_reg + 2'd1;
            end

            // Decode the started transfer.
            S_XSTART:
            begin
                if (xsel != 3'd1 && xsel != 3'd2 && xsel != 3'd4)
                begin
                    if (gi_reg == ngrp_reg)
                        state_next = S_DONE;
                    else
                    begin
                        gi_next    = gi_reg + 2'd1;
                        state_next = S_APPLY;
                    end
                end
                else if (control_reg[xch_reg][1])
                begin
                    xupd_next  = 1'b0;
                    state_next = S_XEND;
                end
                else
                begin
                    xlen_next  = control_reg[xch_reg][5:4];
                    xdir_next  = control_reg[xch_reg][3:2];
                    xupd_next  = control_reg[xch_reg][3:2] == DIR_READ ||
                                 control_reg[xch_reg][3:2] == DIR_XCHG;
                    xboot_next = xch_reg == 2'd0 && xsel == 3'd2;
                    xj_next    = 2'd0;
                    xres_next  = 32'd0;
                    state_next = S_XSTEP;
                end
            end

            // Hand one byte to the device.
            S_XSTEP:
            begin
                boot_req.step = xboot_reg && xdir_reg != DIR_NONE;
                boot_req.din  = (xdir_reg == DIR_READ) ? 8'h00 : xin;
                state_next    = S_XWAIT;
            end

            // Collect the answer byte.
            S_XWAIT:
            begin
                xres_next = xres_reg | (32'(xout) << {~xj_reg, 3'b000});
                if (xj_reg == xlen_reg)
                    state_next = S_XEND;
                else
                begin
                    xj_next    = xj_reg + 2'd1;
                    state_next = S_XSTEP;
                end
            end

            // Transfer complete: clear start, raise TCINT.
            S_XEND:
            begin
                control_next[xch_reg][0] = 1'b0;
                status_next[xch_reg][3]  = 1'b1;
                if (xupd_reg)
                    imm_next[xch_reg] = xres_reg;
                if (gi_reg == ngrp_reg)
                    state_next = S_DONE;
                else
                begin
                    gi_next    = gi_reg + 2'd1;
                    state_next = S_APPLY;
                end
            end

            // Load the result register once it is free.
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    read_value_next = (hit_reg && !cmd_reg) ? rv_reg : 64'd0;
                    claimed_next    = hit_reg;
                    irq_next        = irq_any;
                    state_next      = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_stall    = state_reg != S_IDLE;
    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign claimed     = claimed_reg;
    assign irq_pending = irq_reg;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Channel registers and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg[0] <= 14'h0800;
            status_reg[1] <= 14'h0880;
            status_reg[2] <= 14'h0000;
            dma_addr_reg  <= '{default: 32'd0};
            dma_len_reg   <= '{default: 32'd0};
            control_reg   <= '{default: 32'd0};
            imm_reg       <= '{default: 32'd0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            status_reg    <= status_next;
            dma_addr_reg  <= dma_addr_next;
            dma_len_reg   <= dma_len_next;
            control_reg   <= control_next;
            imm_reg       <= imm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        hit_reg        <= hit_next;
        off_reg        <= off_next;
        size_reg       <= size_next;
        wval_reg       <= wval_next;
        secs_reg       <= secs_next;
        cnt_reg        <= cnt_next;
        rv_reg         <= rv_next;
        gbits_reg      <= gbits_next;
        gmask_reg      <= gmask_next;
        ngrp_reg       <= ngrp_next;
        gi_reg         <= gi_next;
        xch_reg        <= xch_next;
        xlen_reg       <= xlen_next;
        xdir_reg       <= xdir_next;
        xboot_reg      <= xboot_next;
        xupd_reg       <= xupd_next;
        xj_reg         <= xj_next;
        xres_reg       <= xres_next;
        read_value_reg <= read_value_next;
        claimed_reg    <= claimed_next;
        irq_reg        <= irq_next;
    end

endmodule
